// ===== rtl/core/bounded_set_span_engine_core_assert.svh =====
// Assertion helpers for the span engine RTL core.
`ifndef BOUNDED_SET_SPAN_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_SET_SPAN_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BSSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsse: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BSSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsse: next-cycle check failed");

`endif

// ===== rtl/core/bsse_pkg.sv =====
package bsse_pkg;

	localparam int VAL_W = 32;
	localparam int CAP_W = 7;
	localparam int STAT_W = 2;

	localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;
	localparam logic [VAL_W-1:0] GAP_NONE = 32'hFFFF_FFFF;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FEW = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Insert command broadcast to every cell
	typedef struct packed {
		logic             ins_en;
		logic [VAL_W-1:0] key;
	} chain_ctrl_t;

	// What the chain reports back: the head value, and the last value and minimum gap from its end
	typedef struct packed {
		logic [VAL_W-1:0] first_val;
		logic [VAL_W-1:0] last_val;
		logic [VAL_W-1:0] min_gap;
	} chain_stat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  shortest;
		logic [VAL_W-1:0]  longest;
	} result_t;

endpackage

// ===== rtl/core/bsse_if.sv =====
interface bsse_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface bsse_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] shortest_span;
	logic [31:0] longest_span;

	modport source (output valid, output status, output shortest_span,
		output longest_span, input ready);
	modport sink (input valid, input status, input shortest_span,
		input longest_span, output ready);
endinterface

// ===== rtl/core/bsse_cell.sv =====
module bsse_cell import bsse_pkg::*; (
	input  logic             clk,
	input  chain_ctrl_t      ctrl,
	input  logic             head,
	input  logic             occ,
	input  logic             left_live,
	input  logic [VAL_W-1:0] left_val,
	input  logic [VAL_W-1:0] left_min,
	input  logic [VAL_W-1:0] left_last,
	output logic [VAL_W-1:0] val,
	output logic [VAL_W-1:0] min_gap,
	output logic [VAL_W-1:0] last_val
);

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] last_q;
	logic             shift_in;
	logic             take_key;
	logic             gap_ok;
	logic [VAL_W-1:0] gap;

	// Decide whether to take the left value, the new key, or hold
	assign shift_in = left_live && (left_val > ctrl.key);
	assign take_key = !shift_in && (occ ? (val_q > ctrl.key) : (left_live || head));

	// Gap to the left neighbour, only where both are held
	assign gap_ok = occ && left_live;
	assign gap = val_q - left_val;

	// Hold the sorted value
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (shift_in) begin
				val_q <= left_val;
			end else if (take_key) begin
				val_q <= ctrl.key;
			end
		end
	end

	// Advance the minimum and last-value waves one cell per cycle
	always_ff @(posedge clk) begin
		min_q <= (gap_ok && (gap < left_min)) ? gap : left_min;
		last_q <= occ ? val_q : left_last;
	end

	assign val = val_q;
	assign min_gap = min_q;
	assign last_val = last_q;

endmodule

// ===== rtl/core/bsse_chain.sv =====
module bsse_chain import bsse_pkg::*; #(
	parameter int STORE_DEPTH = 64,
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  chain_ctrl_t      ctrl,
	input  logic [CNT_W-1:0] held_count,
	output chain_stat_t      stat
);

	logic [STORE_DEPTH-1:0] occ;
	logic [VAL_W-1:0]       val_w  [STORE_DEPTH];
	logic [VAL_W-1:0]       min_w  [STORE_DEPTH];
	logic [VAL_W-1:0]       last_w [STORE_DEPTH];

	genvar i;
	generate
		for (i = 0; i < STORE_DEPTH; i++) begin : g_cell
			// Mark cells below the fill count as held
			assign occ[i] = CNT_W'(i) < held_count;

			if (i == 0) begin : g_head
				bsse_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl),
					.head      (1'b1),
					.occ       (occ[i]),
					.left_live (1'b0),
					.left_val  ('0),
					.left_min  (GAP_NONE),
					.left_last ('0),
					.val       (val_w[i]),
					.min_gap   (min_w[i]),
					.last_val  (last_w[i])
				);
			end else begin : g_body
				bsse_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl),
					.head      (1'b0),
					.occ       (occ[i]),
					.left_live (occ[i-1]),
					.left_val  (val_w[i-1]),
					.left_min  (min_w[i-1]),
					.left_last (last_w[i-1]),
					.val       (val_w[i]),
					.min_gap   (min_w[i]),
					.last_val  (last_w[i])
				);
			end
		end
	endgenerate

	assign stat.first_val = val_w[0];
	assign stat.last_val = last_w[STORE_DEPTH-1];
	assign stat.min_gap = min_w[STORE_DEPTH-1];

endmodule

// ===== rtl/core/bounded_set_span_engine_core.sv =====
// Add item, or a query with fewer than two values held: result is pushed on accept.
// Query with two or more values: the block scans the chain, and the result is set by the
// gap-minimum wave crossing the cell chain one cell per cycle; one item at a time.
// Adds are taken back to back while the pending slot is empty; a second waiting result is held in a pending slot.
// arst_n clears the fill count, control and output valids, and sets capacity to 64;
// cell contents are not cleared and are never read above the fill count.
`include "bounded_set_span_engine_core_assert.svh"

module bounded_set_span_engine_core import bsse_pkg::*; #(
	parameter int STORE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	bsse_in_if.sink          items,
	bsse_out_if.source       results
);

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int SCAN_W = $clog2(STORE_DEPTH);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(STORE_DEPTH - 1);

	state_t            state_q, state_d;
	logic [SCAN_W-1:0] scan_q, scan_d;
	logic [CNT_W-1:0]  held_count_q;
	logic [CAP_W-1:0]  cap_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              pend_valid_q;
	result_t           pend_q;

	logic        accept;
	logic        room;
	logic        push;
	result_t     push_res;
	logic        pop;
	chain_ctrl_t ctrl;
	chain_stat_t stat;

	// Room left below the smaller of capacity and depth
	assign room = (CMP_W'(held_count_q) < CMP_W'(cap_q)) && (held_count_q < CNT_DEPTH);
	assign accept = items.valid && items.ready;
	assign pop = out_valid_q && results.ready;

	// Next state, handshake and result selection
	always_comb begin
		state_d = state_q;
		scan_d = scan_q;
		items.ready = 1'b0;
		push = 1'b0;
		push_res = '{status: STATUS_OK, shortest: '0, longest: '0};
		ctrl.ins_en = 1'b0;
		ctrl.key = items.value ^ SIGN_BIAS;
		case (state_q)
			ST_IDLE: begin
				items.ready = !pend_valid_q;
				if (items.valid && !pend_valid_q) begin
					if (items.op == OP_ADD) begin
						push = 1'b1;
						if (room) begin
							ctrl.ins_en = 1'b1;
						end else begin
							push_res.status = STATUS_FULL;
						end
					end else if (held_count_q < CNT_TWO) begin
						push = 1'b1;
						push_res.status = STATUS_FEW;
					end else begin
						state_d = ST_SCAN;
						scan_d = '0;
					end
				end
			end
			ST_SCAN: begin
				scan_d = scan_q + SCAN_W'(1);
				if (scan_q == SCAN_LAST) begin
					push = 1'b1;
					push_res.shortest = stat.min_gap;
					push_res.longest = stat.last_val - stat.first_val;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	bsse_chain #(
		.STORE_DEPTH (STORE_DEPTH),
		.CNT_W       (CNT_W)
	) u_chain (
		.clk        (clk),
		.ctrl       (ctrl),
		.held_count (held_count_q),
		.stat       (stat)
	);

	// Hold state, scan position, fill count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q <= '0;
			held_count_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			state_q <= state_d;
			scan_q <= scan_d;
			if (ctrl.ins_en) begin
				held_count_q <= held_count_q + CNT_W'(1);
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// Advance the two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (pop) begin
				pend_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (pop) begin
				out_q <= pend_q;
			end
		end else if (!out_valid_q || pop) begin
			if (push) begin
				out_q <= push_res;
			end
		end else if (push) begin
			pend_q <= push_res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.status = out_q.status;
	assign results.shortest_span = out_q.shortest;
	assign results.longest_span = out_q.longest;

	`BSSE_ASSERT_NOW(a_count_bound, 1'b1, held_count_q <= CNT_DEPTH)
	`BSSE_ASSERT_NOW(a_pend_behind_out, pend_valid_q, out_valid_q)
	`BSSE_ASSERT_NEXT(a_scan_holds_store, state_q == ST_SCAN, $stable(held_count_q))
	`BSSE_ASSERT_NEXT(a_add_grows, accept && items.op == OP_ADD && room, held_count_q == $past(held_count_q) + CNT_W'(1))
	`BSSE_ASSERT_NOW(a_no_push_over_pend, push, !pend_valid_q)

endmodule

// ===== tb/bounded_set_span_engine_core_tb.sv =====
`timescale 1ns / 100ps

module bounded_set_span_engine_core_tb;
	import bsse_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam longint TIMEOUT_NS = 10_000_000;
	localparam int PHASE_ITEMS = 180;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	bsse_in_if item_ch ();
	bsse_out_if result_ch ();

	bounded_set_span_engine_core #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (item_ch),
		.results  (result_ch)
	);

	// Shadow of the block: sorted keys with the sign bit flipped, and the capacity
	logic [31:0] held_keys[$];
	logic [CAP_W-1:0] capacity_reg;
	result_t expected_spans[$];
	int mismatch_count = 0;

	// Sender pacing and receiver hold-off requests
	int burst_left = 0;
	bit sender_gaps_on = 1'b1;
	logic [31:0] cluster_base = '0;
	int hold_requests = 0;
	int hold_taken = 0;
	int hold_len = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the answer to one accepted item and advance the shadow state
	function automatic result_t compute_span_result(input logic op, input logic [31:0] val);
		result_t r;
		logic [31:0] key;
		logic [31:0] gap;
		int pos;
		int room;
		r = '0;
		room = (capacity_reg > STORE_DEPTH) ? STORE_DEPTH : int'(capacity_reg);
		if (op == OP_ADD) begin
			if (held_keys.size() < room) begin
				key = val ^ SIGN_BIAS;
				pos = held_keys.size();
				while (pos > 0 && held_keys[pos-1] > key)
					pos--;
				held_keys.insert(pos, key);
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (held_keys.size() < 2) begin
			r.status = STATUS_FEW;
		end else begin
			r.longest = held_keys[held_keys.size()-1] - held_keys[0];
			r.shortest = GAP_NONE;
			for (int i = 1; i < held_keys.size(); i++) begin
				gap = held_keys[i] - held_keys[i-1];
				if (gap < r.shortest)
					r.shortest = gap;
			end
		end
		return r;
	endfunction

	// Mix of full-range values, tight clusters, duplicates and near-extremes
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1, 2: return $urandom;
			3, 4: return cluster_base + $urandom_range(0, 31);
			5, 6: begin
				if (held_keys.size() > 0)
					return held_keys[$urandom_range(0, held_keys.size() - 1)] ^ SIGN_BIAS;
				return $urandom;
			end
			default: begin
				if ($urandom_range(0, 1))
					return 32'h8000_0000 + $urandom_range(0, 15);
				return 32'h7FFF_FFFF - $urandom_range(0, 15);
			end
		endcase
	endfunction

	// Close a burst now and then with an idle gap
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one item and hold it until the block takes it
	task automatic send_item(input logic op, input logic [31:0] val);
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.value <= val;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		expected_spans.insert(expected_spans.size(), compute_span_result(op, val));
		pace_sender();
	endtask

	// Write the capacity once every answer is back
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_spans.size() != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = cap;
	endtask

	task automatic test_reset_state();
		send_item(OP_QUERY, 32'h0);
		send_item(OP_ADD, -32'sd7);
		send_item(OP_QUERY, 32'hFFFF_FFFF);
	endtask

	task automatic test_capacity_refusal();
		write_capacity(7'd0);
		send_item(OP_ADD, 32'h8000_0000);
		send_item(OP_ADD, 32'h7FFF_FFFF);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_ADD, 32'h5555_5555);
		send_item(OP_ADD, 32'hAAAA_AAAA);
		send_item(OP_QUERY, 32'h5555_5555);
	endtask

	task automatic test_span_basics();
		write_capacity(7'd3);
		send_item(OP_ADD, -32'sd7);
		send_item(OP_QUERY, 32'hAAAA_AAAA);
		send_item(OP_ADD, 32'd100);
		send_item(OP_QUERY, 32'h0);
		send_item(OP_ADD, 32'd5);
	endtask

	task automatic test_capacity_below_count();
		write_capacity(7'd2);
		send_item(OP_ADD, 32'd9);
		send_item(OP_QUERY, 32'h0);
	endtask

	// Stall the result side for a long stretch while adds keep coming
	task automatic test_result_backpressure();
		write_capacity(7'd8);
		sender_gaps_on = 1'b0;
		hold_len = 200;
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_item(OP_ADD, pick_value());
		send_item(OP_QUERY, $urandom);
		sender_gaps_on = 1'b1;
	endtask

	task automatic test_extreme_span();
		write_capacity(7'd46);
		send_item(OP_ADD, 32'h8000_0000);
		send_item(OP_ADD, 32'h7FFF_FFFF);
		send_item(OP_QUERY, $urandom);
	endtask

	task automatic test_random_phase(input logic [CAP_W-1:0] cap, input bit gaps_on);
		write_capacity(cap);
		cluster_base = $urandom;
		sender_gaps_on = gaps_on;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 40)
				send_item(OP_QUERY, $urandom);
			else
				send_item(OP_ADD, pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_ADD;
		item_ch.value = '0;
		held_keys.delete();
		capacity_reg = CAP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_capacity_refusal();
		test_span_basics();
		test_capacity_below_count();
		test_result_backpressure();
		test_random_phase(7'd6, 1'b1);
		test_random_phase(7'd10, 1'b0);
		test_random_phase(7'd16, 1'b1);
		test_random_phase(7'd24, 1'b1);
		test_random_phase(7'd32, 1'b1);
		test_random_phase(7'd44, 1'b0);
		test_extreme_span();
		test_random_phase(7'd56, 1'b1);
		// Capacity above the store depth: fills to the depth only
		test_random_phase(7'd127, 1'b1);
		test_random_phase(7'd64, 1'b1);

		// Drain, then allow for a stray late result
		item_ch.valid <= 1'b0;
		while (expected_spans.size() != 0)
			@(posedge clk);
		repeat (STORE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("bounded_set_span_engine_core regression: pass");
		else
			$display("bounded_set_span_engine_core regression: fail");
		$finish;
	end

	// Result ready: free-running, random or masked pattern, plus requested hold-offs
	initial begin : drive_result_ready
		int hold_left;
		int mode;
		int span_left;
		logic [7:0] mask;
		hold_left = 0;
		mode = 0;
		span_left = 0;
		mask = 8'hFF;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != hold_taken) begin
				hold_taken = hold_requests;
				hold_left = hold_len;
			end
			if (span_left == 0) begin
				mode = $urandom_range(0, 2);
				span_left = $urandom_range(50, 300);
				mask = 8'($urandom) | 8'h01;
			end
			span_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						result_ch.ready <= mask[0];
						mask = {mask[0], mask[7:1]};
					end
				endcase
			end
		end
	end

	task automatic compare_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_spans.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %h short %h long %h",
					$time, result_ch.status, result_ch.shortest_span, result_ch.longest_span);
				mismatch_count++;
			end else begin
				want = expected_spans.pop_front();
				compare_field("status", 32'(want.status), 32'(result_ch.status));
				compare_field("shortest_span", want.shortest, result_ch.shortest_span);
				compare_field("longest_span", want.longest, result_ch.longest_span);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("bounded_set_span_engine_core regression: fail");
		$finish;
	end

endmodule
